/* rtl/core/assert_macros.svh */
// Assertion macros for the checker file of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define MLD_ASSERT_CLK(label, ck, rn, prop, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Concurrent assertion on the block clock clk and reset arst_n.
`define MLD_ASSERT(label, prop, msg) \
	`MLD_ASSERT_CLK(label, clk, arst_n, prop, msg)

`endif

/* rtl/core/mld_pkg.sv */
// Package of types, constants and codes for the MRU list block.
`timescale 1ns / 1ps

package mld_pkg;

	localparam int CAPACITY  = 16;
	localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int PAY_W     = 32;
	localparam int KEY_W     = 64;
	localparam int FUNC_W    = 2;
	localparam int SLOT_W    = 4;
	localparam int CNT_OUT_W = 5;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_RECORD = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_CLEAR  = 2'd2,
		FUNC_READ   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMPACT,
		ST_SHIFT,
		ST_REMOVE,
		ST_INSERT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [PAY_W-1:0] payload;
		logic [KEY_W-1:0] key;
	} entry_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
	} mem_req_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] prior;
		logic             prior_on;
	} match_req_t;

endpackage

/* rtl/core/mld_store.sv */
// Entry store: one write port and one registered read port.
`timescale 1ns / 1ps

module mld_store (
	input  logic              clk,
	input  mld_pkg::mem_req_t mem_req,
	output mld_pkg::entry_t   rd_data_q
);
	import mld_pkg::*;

	entry_t mem_q [CAPACITY];

	always_ff @(posedge clk) begin
		if (mem_req.wr_en) begin
			mem_q[mem_req.wr_addr] <= mem_req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_req.rd_en) begin
			rd_data_q <= mem_q[mem_req.rd_addr];
		end
	end

endmodule

/* rtl/core/mld_match.sv */
// Shared key compare unit: flags an entry whose key hits the new or prior key.
`timescale 1ns / 1ps

module mld_match (
	input  mld_pkg::match_req_t           match_req,
	input  logic [mld_pkg::KEY_W-1:0]     entry_key,
	output logic                          drop
);
	import mld_pkg::*;

	assign drop = (entry_key == match_req.key) ||
		(match_req.prior_on && (entry_key == match_req.prior));

endmodule

/* rtl/core/mld_ctrl.sv */
// Sequencer: walks the store for record and remove, reads it for read, resets the count for clear, holds the result.
`timescale 1ns / 1ps

module mld_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [mld_pkg::FUNC_W-1:0]        func,
	input  logic [mld_pkg::PAY_W-1:0]         payload_word,
	input  logic                              payload_present,
	input  logic [mld_pkg::KEY_W-1:0]         doc_key,
	input  logic                              key_valid,
	input  logic [mld_pkg::KEY_W-1:0]         prior_key,
	input  logic                              prior_valid,
	input  logic [mld_pkg::SLOT_W-1:0]        slot_index,
	input  logic                              drop,
	input  mld_pkg::entry_t                   rd_data_q,
	output mld_pkg::mem_req_t                 mem_req,
	output mld_pkg::match_req_t               match_req,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              done_ok,
	output logic [mld_pkg::PAY_W-1:0]         out_payload,
	output logic [mld_pkg::KEY_W-1:0]         out_key,
	output logic [mld_pkg::CNT_OUT_W-1:0]     entry_count
);
	import mld_pkg::*;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   iss_q, iss_d;
	logic [CNT_W-1:0]   iss_dec;
	logic [IDX_W-1:0]   wa_q, wa_d;
	logic               pend_q;
	logic [CNT_W-1:0]   kept_q, kept_d;
	logic [CNT_W-1:0]   shift_len;
	logic [CNT_W-1:0]   count_q, count_d;
	logic               ok_q, ok_d;
	logic               rdres_q, rdres_d;
	logic               load_req;
	logic               out_load;
	logic               idx_hit;

	logic [PAY_W-1:0]   req_payload_q;
	logic [KEY_W-1:0]   req_key_q;
	logic [KEY_W-1:0]   req_prior_q;
	logic               req_prior_on_q;

	logic               out_valid_q;
	logic               done_ok_q;
	logic [PAY_W-1:0]   out_payload_q;
	logic [KEY_W-1:0]   out_key_q;
	logic [CNT_OUT_W-1:0] entry_count_q;

	assign idx_hit   = 32'(slot_index) < 32'(count_q);
	assign iss_dec   = iss_q - CNT_W'(1);
	assign shift_len = (kept_q == CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY - 1) : kept_q;

	assign match_req.key      = req_key_q;
	assign match_req.prior    = req_prior_q;
	assign match_req.prior_on = req_prior_on_q;

	always_comb begin
		state_d  = state_q;
		iss_d    = iss_q;
		wa_d     = wa_q;
		kept_d   = kept_q;
		count_d  = count_q;
		ok_d     = ok_q;
		rdres_d  = rdres_q;
		load_req = 1'b0;
		out_load = 1'b0;
		mem_req         = '0;
		mem_req.wr_data = rd_data_q;
		in_stall = (state_q != ST_IDLE);

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					load_req = 1'b1;
					ok_d     = 1'b0;
					rdres_d  = 1'b0;
					state_d  = ST_DONE;
					case (func_t'(func))
						FUNC_RECORD: begin
							if (payload_present && key_valid) begin
								iss_d   = '0;
								kept_d  = '0;
								state_d = ST_COMPACT;
							end
						end
						FUNC_REMOVE: begin
							if (idx_hit) begin
								iss_d   = CNT_W'(slot_index) + CNT_W'(1);
								state_d = ST_REMOVE;
							end
						end
						FUNC_CLEAR: begin
							count_d = '0;
							ok_d    = 1'b1;
						end
						FUNC_READ: begin
							if (idx_hit) begin
								mem_req.rd_en   = 1'b1;
								mem_req.rd_addr = IDX_W'(slot_index);
								ok_d            = 1'b1;
								rdres_d         = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			ST_COMPACT: begin
				// read each held entry, write survivors down to the kept pointer
				if (iss_q < count_q) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = iss_q[IDX_W-1:0];
					iss_d           = iss_q + CNT_W'(1);
				end
				if (pend_q && !drop) begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = kept_q[IDX_W-1:0];
					kept_d          = kept_q + CNT_W'(1);
				end
				if ((iss_q == count_q) && !pend_q) begin
					iss_d   = shift_len;
					kept_d  = shift_len;
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				// move entries up one place, from the tail down to slot 1
				if (iss_q != '0) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = iss_dec[IDX_W-1:0];
					wa_d            = iss_q[IDX_W-1:0];
					iss_d           = iss_dec;
				end
				if (pend_q) begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = wa_q;
				end
				if ((iss_q == '0) && !pend_q) begin
					state_d = ST_INSERT;
				end
			end
			ST_INSERT: begin
				mem_req.wr_en           = 1'b1;
				mem_req.wr_addr         = '0;
				mem_req.wr_data.payload = req_payload_q;
				mem_req.wr_data.key     = req_key_q;
				count_d                 = kept_q + CNT_W'(1);
				ok_d                    = 1'b1;
				state_d                 = ST_DONE;
			end
			ST_REMOVE: begin
				// pull each later entry down one place
				if (iss_q < count_q) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = iss_q[IDX_W-1:0];
					wa_d            = iss_dec[IDX_W-1:0];
					iss_d           = iss_q + CNT_W'(1);
				end
				if (pend_q) begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = wa_q;
				end
				if ((iss_q >= count_q) && !pend_q) begin
					count_d = count_q - CNT_W'(1);
					ok_d    = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iss_q       <= '0;
			wa_q        <= '0;
			pend_q      <= 1'b0;
			kept_q      <= '0;
			count_q     <= '0;
			ok_q        <= 1'b0;
			rdres_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			iss_q   <= iss_d;
			wa_q    <= wa_d;
			pend_q  <= mem_req.rd_en;
			kept_q  <= kept_d;
			count_q <= count_d;
			ok_q    <= ok_d;
			rdres_q <= rdres_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_req) begin
			req_payload_q  <= payload_word;
			req_key_q      <= doc_key;
			req_prior_q    <= prior_key;
			req_prior_on_q <= prior_valid;
		end
		if (out_load) begin
			done_ok_q     <= ok_q;
			out_payload_q <= rdres_q ? rd_data_q.payload : '0;
			out_key_q     <= rdres_q ? rd_data_q.key : '0;
			entry_count_q <= CNT_OUT_W'(count_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign done_ok     = done_ok_q;
	assign out_payload = out_payload_q;
	assign out_key     = out_key_q;
	assign entry_count = entry_count_q;

endmodule

/* rtl/core/mru_list_dedup_insert.sv */
// Top level of the bounded most-recently-used list with duplicate drop on record.
// Read, clear and refused requests go from idle straight to the done state; remove runs the
// pull-down pass, and record runs the compaction pass, the shift pass and the front write.
// One request at a time: no new request is taken until the last one leaves the done state,
// and a stalled result holds the next request in the done state.
// Reset (arst_n low, asynchronous) empties the list and drops any pending result.
`timescale 1ns / 1ps

module mru_list_dedup_insert (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [mld_pkg::FUNC_W-1:0]        func,
	input  logic [mld_pkg::PAY_W-1:0]         payload_word,
	input  logic                              payload_present,
	input  logic [mld_pkg::KEY_W-1:0]         doc_key,
	input  logic                              key_valid,
	input  logic [mld_pkg::KEY_W-1:0]         prior_key,
	input  logic                              prior_valid,
	input  logic [mld_pkg::SLOT_W-1:0]        slot_index,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              done_ok,
	output logic [mld_pkg::PAY_W-1:0]         out_payload,
	output logic [mld_pkg::KEY_W-1:0]         out_key,
	output logic [mld_pkg::CNT_OUT_W-1:0]     entry_count
);
	import mld_pkg::*;

	// Store port request from the sequencer; the read data is registered and comes back in the next cycle.
	mem_req_t   mem_req;
	entry_t     rd_data_q;
	// Keys of the request in flight, fed to the shared compare unit.
	match_req_t match_req;
	logic       drop;

	// Sequencer: a record request runs a compaction pass (read every held entry,
	// drop key hits, write survivors down), a shift pass (move the kept entries up
	// one slot, evicting the oldest when full) and one write of the new entry at
	// the front. Remove pulls later entries down one slot. Read issues one store
	// read. The result register frees the request side while a result waits.
	mld_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.payload_word    (payload_word),
		.payload_present (payload_present),
		.doc_key         (doc_key),
		.key_valid       (key_valid),
		.prior_key       (prior_key),
		.prior_valid     (prior_valid),
		.slot_index      (slot_index),
		.drop            (drop),
		.rd_data_q       (rd_data_q),
		.mem_req         (mem_req),
		.match_req       (match_req),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.done_ok         (done_ok),
		.out_payload     (out_payload),
		.out_key         (out_key),
		.entry_count     (entry_count)
	);

	// Entry store: slots at or above the count are never read, so it needs no clearing.
	mld_store u_store (
		.clk       (clk),
		.mem_req   (mem_req),
		.rd_data_q (rd_data_q)
	);

	// Compare the entry just read against the new key and, when given, the prior key.
	mld_match u_match (
		.match_req (match_req),
		.entry_key (rd_data_q.key),
		.drop      (drop)
	);

endmodule

/* rtl/core/mld_checker.sv */
// Port-level checker for the MRU list block and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mld_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          done_ok,
	input logic [mld_pkg::PAY_W-1:0]     out_payload,
	input logic [mld_pkg::KEY_W-1:0]     out_key
);

	// One request at a time: the request side closes right after an accept.
	`MLD_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall, "request side open after accept")

	// A failed request returns zero payload and key; so does a non-read, which this does not check.
	`MLD_ASSERT(a_fail_zero_fields, (out_valid && !done_ok) |-> (out_payload == '0 && out_key == '0), "failed result carries data")

	// A fresh result only follows a cycle in which the request side was busy.
	`MLD_ASSERT(a_result_after_work, $rose(out_valid) |-> $past(in_stall), "result without a request in work")

	// A stalled result holds.
	`MLD_ASSERT(a_result_holds, (out_valid && out_stall) |=> (out_valid && $stable(done_ok) && $stable(out_key)), "stalled result changed")

endmodule

bind mru_list_dedup_insert mld_checker u_mld_checker (.*);

/* tb/mru_list_checker.sv */
// Request/result monitor with MRU list predictor and in-order result comparison.
`timescale 1ns / 1ps

module mru_list_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [mld_pkg::FUNC_W-1:0]    func,
	input  logic [mld_pkg::PAY_W-1:0]     payload_word,
	input  logic                          payload_present,
	input  logic [mld_pkg::KEY_W-1:0]     doc_key,
	input  logic                          key_valid,
	input  logic [mld_pkg::KEY_W-1:0]     prior_key,
	input  logic                          prior_valid,
	input  logic [mld_pkg::SLOT_W-1:0]    slot_index,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic                          done_ok,
	input  logic [mld_pkg::PAY_W-1:0]     out_payload,
	input  logic [mld_pkg::KEY_W-1:0]     out_key,
	input  logic [mld_pkg::CNT_OUT_W-1:0] entry_count,
	output int                            fail_count,
	output int                            pending
);
	import mld_pkg::*;

	typedef struct packed {
		logic                 ok;
		logic [PAY_W-1:0]     payload;
		logic [KEY_W-1:0]     key;
		logic [CNT_OUT_W-1:0] count;
	} reply_t;

	// Predicted list contents, position 0 most recent.
	logic [PAY_W-1:0] list_pay [CAPACITY];
	logic [KEY_W-1:0] list_key [CAPACITY];
	int               list_len;
	reply_t           replies_due [$];

	// Apply one request to the predicted list and return the result it yields.
	function automatic reply_t apply_request(func_t op, logic [PAY_W-1:0] pay, logic pres,
			logic [KEY_W-1:0] key, logic kv, logic [KEY_W-1:0] prior, logic pv,
			logic [SLOT_W-1:0] idx);
		reply_t r;
		int     kept;
		r = '0;
		case (op)
			FUNC_RECORD: begin
				if (pres && kv) begin
					// drop duplicates of the new key and of the prior key, keep order
					kept = 0;
					for (int i = 0; i < list_len; i++) begin
						if (!(list_key[i] == key || (pv && list_key[i] == prior))) begin
							list_pay[kept] = list_pay[i];
							list_key[kept] = list_key[i];
							kept++;
						end
					end
					// evict the oldest when still full
					if (kept >= CAPACITY)
						kept = CAPACITY - 1;
					for (int i = kept; i > 0; i--) begin
						list_pay[i] = list_pay[i-1];
						list_key[i] = list_key[i-1];
					end
					list_pay[0] = pay;
					list_key[0] = key;
					list_len = kept + 1;
					r.ok = 1'b1;
				end
			end
			FUNC_REMOVE: begin
				if (idx < list_len) begin
					for (int i = idx; i + 1 < list_len; i++) begin
						list_pay[i] = list_pay[i+1];
						list_key[i] = list_key[i+1];
					end
					list_len--;
					r.ok = 1'b1;
				end
			end
			FUNC_CLEAR: begin
				list_len = 0;
				r.ok = 1'b1;
			end
			default: begin
				if (idx < list_len) begin
					r.payload = list_pay[idx];
					r.key = list_key[idx];
					r.ok = 1'b1;
				end
			end
		endcase
		r.count = list_len[CNT_OUT_W-1:0];
		return r;
	endfunction

	function automatic int field_miss(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		int     errs;
		if (!arst_n) begin
			list_len = 0;
			replies_due.delete();
			pending <= 0;
			fail_count <= 0;
		end else begin
			errs = 0;
			// compare first: a result leaving now belongs to an older request
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					$display("%0t: result with no request due, actual ok=%0b payload=%h key=%h count=%0d",
						$time, done_ok, out_payload, out_key, entry_count);
					errs++;
				end else begin
					want = replies_due.pop_front();
					errs += field_miss("done_ok", KEY_W'(want.ok), KEY_W'(done_ok));
					errs += field_miss("out_payload", KEY_W'(want.payload), KEY_W'(out_payload));
					errs += field_miss("out_key", want.key, out_key);
					errs += field_miss("entry_count", KEY_W'(want.count), KEY_W'(entry_count));
				end
			end
			if (in_valid && !in_stall)
				replies_due.push_back(apply_request(func_t'(func), payload_word,
					payload_present, doc_key, key_valid, prior_key, prior_valid, slot_index));
			fail_count <= fail_count + errs;
			pending <= replies_due.size();
		end
	end

endmodule

/* tb/mru_list_dedup_insert_test.sv */
// Top level test of the MRU list: request stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module mru_list_dedup_insert_test;
	import mld_pkg::*;

	// Long output hold in the pressure phase; the watchdog limit sits well above it
	// plus the slowest record.
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int PHASE_ITEMS    = 186;
	localparam int POOL_SIZE      = 24;
	localparam logic [KEY_W-1:0] KEY_ONES = '1;
	localparam logic [PAY_W-1:0] PAY_ONES = '1;

	logic                 clk             = 1'b0;
	logic                 arst_n          = 1'b0;
	logic                 in_valid        = 1'b0;
	logic                 in_stall;
	logic [FUNC_W-1:0]    func            = '0;
	logic [PAY_W-1:0]     payload_word    = '0;
	logic                 payload_present = 1'b0;
	logic [KEY_W-1:0]     doc_key         = '0;
	logic                 key_valid       = 1'b0;
	logic [KEY_W-1:0]     prior_key       = '0;
	logic                 prior_valid     = 1'b0;
	logic [SLOT_W-1:0]    slot_index      = '0;
	logic                 out_valid;
	logic                 out_stall       = 1'b0;
	logic                 done_ok;
	logic [PAY_W-1:0]     out_payload;
	logic [KEY_W-1:0]     out_key;
	logic [CNT_OUT_W-1:0] entry_count;

	int fail_count;
	int pending;

	// Handshake pressure knobs, in percent per cycle.
	int idle_pct  = 0;
	int stall_pct = 0;
	// Bumped by the stimulus to start a long output hold; the receiver counts it out.
	int hold_token = 0;
	int hold_seen  = 0;
	int hold_left  = 0;
	int quiet_cycles = 0;
	int op_tally [4];
	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	mru_list_dedup_insert dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.payload_word    (payload_word),
		.payload_present (payload_present),
		.doc_key         (doc_key),
		.key_valid       (key_valid),
		.prior_key       (prior_key),
		.prior_valid     (prior_valid),
		.slot_index      (slot_index),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.done_ok         (done_ok),
		.out_payload     (out_payload),
		.out_key         (out_key),
		.entry_count     (entry_count)
	);

	mru_list_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.payload_word    (payload_word),
		.payload_present (payload_present),
		.doc_key         (doc_key),
		.key_valid       (key_valid),
		.prior_key       (prior_key),
		.prior_valid     (prior_valid),
		.slot_index      (slot_index),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.done_ok         (done_ok),
		.out_payload     (out_payload),
		.out_key         (out_key),
		.entry_count     (entry_count),
		.fail_count      (fail_count),
		.pending         (pending)
	);

	// Receiver: a pending hold request wins, then count the hold out, otherwise
	// stall at random at the current rate.
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Watchdog: end the run if no request and no result moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, no handshake for %0d cycles, %0d results due",
				$time, quiet_cycles, pending);
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one request and hold it until the block takes it. Idle gaps come
	// first so that valid never drops and rises again within one edge.
	task automatic send_request(func_t op, logic [PAY_W-1:0] pay, logic pres,
			logic [KEY_W-1:0] key, logic kv, logic [KEY_W-1:0] prior, logic pv,
			logic [SLOT_W-1:0] idx);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		func            <= op;
		payload_word    <= pay;
		payload_present <= pres;
		doc_key         <= key;
		key_valid       <= kv;
		prior_key       <= prior;
		prior_valid     <= pv;
		slot_index      <= idx;
		do
			@(posedge clk);
		while (in_stall);
		op_tally[op]++;
	endtask

	// Random request: mostly records over a small key pool so that duplicates,
	// prior-key drops and eviction from a full list happen often; some fresh
	// keys and refused records as noise.
	task automatic issue_random();
		int               pick;
		func_t            op;
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] prior;
		pick = $urandom_range(0, 199);
		if (pick < 3)
			op = FUNC_CLEAR;
		else if (pick < 30)
			op = FUNC_REMOVE;
		else if (pick < 85)
			op = FUNC_READ;
		else
			op = FUNC_RECORD;
		key = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom}
			: key_pool[$urandom_range(0, POOL_SIZE-1)];
		prior = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom}
			: key_pool[$urandom_range(0, POOL_SIZE-1)];
		send_request(op, $urandom, $urandom_range(0, 19) != 0, key,
			$urandom_range(0, 19) != 0, prior, 1'($urandom_range(0, 1)),
			SLOT_W'($urandom_range(0, 15)));
	endtask

	initial begin
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = {$urandom, $urandom};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-list corners, field extremes, refused records,
		// prior key given and not given, indexes at and past the count.
		send_request(FUNC_CLEAR, '0, 1'b0, '0, 1'b0, '0, 1'b0, '0);
		send_request(FUNC_READ, '0, 1'b0, '0, 1'b0, '0, 1'b0, 4'd0);
		send_request(FUNC_REMOVE, '0, 1'b0, '0, 1'b0, '0, 1'b0, 4'd0);
		send_request(FUNC_RECORD, '0, 1'b1, '0, 1'b1, KEY_ONES, 1'b0, '0);
		send_request(FUNC_RECORD, PAY_ONES, 1'b1, KEY_ONES, 1'b1, '0, 1'b0, '1);
		// prior key matches the zero-key entry and drops it
		send_request(FUNC_RECORD, 32'h0000_00a5, 1'b1, key_pool[0], 1'b1, '0, 1'b1, '0);
		send_request(FUNC_RECORD, 32'h1234_5678, 1'b0, key_pool[1], 1'b1, '0, 1'b0, '0);
		send_request(FUNC_RECORD, 32'h1234_5678, 1'b1, key_pool[1], 1'b0, '0, 1'b0, '0);
		send_request(FUNC_RECORD, 32'h1234_5678, 1'b0, key_pool[1], 1'b0, '0, 1'b0, '0);
		send_request(FUNC_READ, '0, 1'b0, '0, 1'b0, '0, 1'b0, 4'd0);
		send_request(FUNC_READ, '0, 1'b0, '0, 1'b0, '0, 1'b0, 4'd1);
		send_request(FUNC_READ, '0, 1'b0, '0, 1'b0, '0, 1'b0, 4'd2);
		send_request(FUNC_READ, PAY_ONES, 1'b1, KEY_ONES, 1'b1, KEY_ONES, 1'b1, 4'd15);
		// duplicate key moves to the front with the new payload
		send_request(FUNC_RECORD, 32'h0000_0005, 1'b1, KEY_ONES, 1'b1, '0, 1'b0, '0);
		// prior key not given: the entry with that key stays
		send_request(FUNC_RECORD, 32'h0000_0006, 1'b1, key_pool[2], 1'b1, key_pool[0],
			1'b0, '0);
		send_request(FUNC_REMOVE, '0, 1'b0, '0, 1'b0, '0, 1'b0, 4'd15);
		send_request(FUNC_REMOVE, '0, 1'b0, '0, 1'b0, '0, 1'b0, 4'd2);
		send_request(FUNC_REMOVE, '0, 1'b0, '0, 1'b0, '0, 1'b0, 4'd0);
		send_request(FUNC_READ, '0, 1'b0, '0, 1'b0, '0, 1'b0, 4'd0);
		send_request(FUNC_RECORD, 32'h0000_0007, 1'b1, key_pool[0], 1'b1, KEY_ONES,
			1'b1, '0);
		send_request(FUNC_CLEAR, PAY_ONES, 1'b1, KEY_ONES, 1'b1, KEY_ONES, 1'b1, '1);
		send_request(FUNC_READ, '0, 1'b0, '0, 1'b0, '0, 1'b0, 4'd0);

		// Random phases: free flow, idle sender, stalling receiver, both, and a
		// long output hold while the sender keeps offering requests.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					idle_pct = 0;
					stall_pct <= 0;
				end
				1: begin
					idle_pct = 51;
					stall_pct <= 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct <= 51;
				end
				3: begin
					idle_pct = 33;
					stall_pct <= 33;
				end
				default: begin
					idle_pct = 0;
					stall_pct <= 0;
					hold_token <= hold_token + 1;
				end
			endcase
			repeat (PHASE_ITEMS)
				issue_random();
		end
		in_valid <= 1'b0;

		// Let the pending count settle, drain it, then give the block time to
		// show any stray result.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d records, %0d removes, %0d clears, %0d reads",
			op_tally[FUNC_RECORD], op_tally[FUNC_REMOVE], op_tally[FUNC_CLEAR],
			op_tally[FUNC_READ]);
		$display("under free flow, sender gaps, receiver stalls, both, and a %0d-cycle hold",
			HOLD_CYCLES);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/mld_pkg.sv
rtl/core/mld_store.sv
rtl/core/mld_match.sv
rtl/core/mld_ctrl.sv
rtl/core/mru_list_dedup_insert.sv
rtl/core/mld_checker.sv
tb/mru_list_checker.sv
tb/mru_list_dedup_insert_test.sv
